// ===== rtl/core/rfpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rfpf_pkg
// Types, constants and helper functions shared by the packet framer modules.
// ----------------------------------------------------------------------------
package rfpf_pkg;

   localparam int unsigned RFPF_QUEUE_DEPTH = 2;

   localparam logic [7:0] FRAME_PREAMBLE = 8'h55;
   localparam logic [7:0] PKT_MAGIC      = 8'hA7;
   localparam logic [7:0] PKT_TYPE       = 8'h01;
   localparam logic [7:0] PKT_PAD        = 8'h00;
   localparam logic [7:0] LEN_PROTOCOL   = 8'd12;
   localparam logic [7:0] LEN_PLAIN      = 8'd4;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [31:0] DEFAULT_PAYLOAD = 32'h0403_0201;

   localparam logic [7:0] RST_SESSION_ID    = 8'd33;
   localparam logic [5:0] RST_FIXED_CHANNEL = 6'd16;

   localparam int unsigned HOP_COUNT = 9;

   // byte positions within a frame
   localparam logic [3:0] POS_PREAMBLE = 4'd0;
   localparam logic [3:0] POS_LENGTH   = 4'd1;
   localparam logic [3:0] POS_MAGIC    = 4'd2;
   localparam logic [3:0] POS_TYPE     = 4'd3;
   localparam logic [3:0] POS_SESSION  = 4'd4;
   localparam logic [3:0] POS_SEQ      = 4'd5;
   localparam logic [3:0] POS_PAD0     = 4'd6;
   localparam logic [3:0] POS_PAD1     = 4'd7;
   localparam logic [3:0] POS_PAY0     = 4'd8;
   localparam logic [3:0] POS_PAY3     = 4'd11;
   localparam logic [3:0] POS_CRC_LO   = 4'd12;
   localparam logic [3:0] POS_CRC_HI   = 4'd13;
   localparam logic [3:0] POS_PLAIN_PAY0 = 4'd2;
   localparam logic [3:0] LAST_PROTOCOL  = 4'd13;
   localparam logic [3:0] LAST_PLAIN     = 4'd5;

   typedef enum logic [1:0] {
      CSR_PROTOCOL_MODE = 2'd0,
      CSR_HOP_ENABLE    = 2'd1,
      CSR_SESSION_ID    = 2'd2,
      CSR_FIXED_CHANNEL = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        payload_valid;
      logic [31:0] payload_word;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
      logic [5:0] radio_channel;
   } rsp_type;

   // one frame job handed from the front end to the byte sequencer
   typedef struct packed {
      logic        protocol;
      logic [7:0]  session_id;
      logic [7:0]  seq;
      logic [31:0] payload;
      logic [5:0]  channel;
   } frame_desc_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // channel = 4 + 4 * ((seq / 16) mod 9)
   function automatic logic [5:0] hop_channel(input logic [7:0] seq);
      logic [3:0] dwell;
      logic [3:0] slot;
      dwell = seq[7:4];
      slot  = (dwell >= 4'(HOP_COUNT)) ? (dwell - 4'(HOP_COUNT)) : dwell;
      return {slot, 2'b00} + 6'd4;
   endfunction

endpackage

// ===== rtl/core/rfpf_front.sv =====
// ----------------------------------------------------------------------------
// rfpf_front
// Register file, payload latch and sequence state; builds one frame job per accepted beat.
// ----------------------------------------------------------------------------
module rfpf_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [1:0]              csr_index,
   input  logic [7:0]              csr_wdata,
   input  logic                    req_push,
   input  rfpf_pkg::req_type       req_data,
   input  logic                    q_full,
   output logic                    q_push,
   output rfpf_pkg::frame_desc_type q_data
);
   import rfpf_pkg::*;

   logic       protocol_mode_ff, protocol_mode_in;
   logic       hop_enable_ff, hop_enable_in;
   logic [7:0] session_id_ff, session_id_in;
   logic [5:0] fixed_channel_ff, fixed_channel_in;
   logic [7:0] seq_ff, seq_in;
   logic [7:0] last_seq_ff, last_seq_in;
   logic [31:0] held_payload_ff, held_payload_in;
   logic       payload_seen_ff, payload_seen_in;
   logic       accept;
   csr_index_type csr_sel;

   assign accept  = req_push && !q_full;
   assign csr_sel = csr_index_type'(csr_index);

   always_comb begin
      protocol_mode_in = protocol_mode_ff;
      hop_enable_in    = hop_enable_ff;
      session_id_in    = session_id_ff;
      fixed_channel_in = fixed_channel_ff;
      if (csr_wr_en) begin
         case (csr_sel)
            CSR_PROTOCOL_MODE: protocol_mode_in = csr_wdata[0];
            CSR_HOP_ENABLE:    hop_enable_in    = csr_wdata[0];
            CSR_SESSION_ID:    session_id_in    = csr_wdata;
            CSR_FIXED_CHANNEL: fixed_channel_in = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      held_payload_in = held_payload_ff;
      payload_seen_in = payload_seen_ff;
      seq_in          = seq_ff;
      last_seq_in     = last_seq_ff;
      if (accept) begin
         if (req_data.payload_valid) begin
            held_payload_in = req_data.payload_word;
            payload_seen_in = 1'b1;
         end
         if (protocol_mode_ff) begin
            last_seq_in = seq_ff;
            seq_in      = seq_ff + 8'd1;
         end
      end
   end

   always_comb begin
      q_push            = accept;
      q_data.protocol   = protocol_mode_ff;
      q_data.session_id = session_id_ff;
      q_data.seq        = seq_ff;
      q_data.payload    = payload_seen_in ? held_payload_in : DEFAULT_PAYLOAD;
      q_data.channel    = hop_enable_ff ? hop_channel(last_seq_in) : fixed_channel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_mode_ff <= 1'b0;
         hop_enable_ff    <= 1'b0;
         session_id_ff    <= RST_SESSION_ID;
         fixed_channel_ff <= RST_FIXED_CHANNEL;
         seq_ff           <= '0;
         last_seq_ff      <= '0;
         held_payload_ff  <= '0;
         payload_seen_ff  <= 1'b0;
      end else begin
         protocol_mode_ff <= protocol_mode_in;
         hop_enable_ff    <= hop_enable_in;
         session_id_ff    <= session_id_in;
         fixed_channel_ff <= fixed_channel_in;
         seq_ff           <= seq_in;
         last_seq_ff      <= last_seq_in;
         held_payload_ff  <= held_payload_in;
         payload_seen_ff  <= payload_seen_in;
      end
   end

endmodule

// ===== rtl/core/rfpf_queue.sv =====
// ----------------------------------------------------------------------------
// rfpf_queue
// Small frame job queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module rfpf_queue #(
   parameter int unsigned DEPTH = rfpf_pkg::RFPF_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rfpf_pkg::frame_desc_type push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output rfpf_pkg::frame_desc_type pop_data
);
   import rfpf_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   frame_desc_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/rfpf_back.sv =====
// ----------------------------------------------------------------------------
// rfpf_back
// Byte sequencer: walks one frame job, runs the CRC a byte per cycle unless
// the rsp side stalls it, and drives the result register.
// ----------------------------------------------------------------------------
module rfpf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  rfpf_pkg::frame_desc_type q_data,
   output logic                     q_pop,
   output logic                     rsp_valid,
   output rfpf_pkg::rsp_type        rsp_data,
   input  logic                     rsp_pop
);
   import rfpf_pkg::*;

   frame_desc_type desc_ff, desc_in;
   logic           active_ff, active_in;
   logic [3:0]     idx_ff, idx_in;
   logic [15:0]    crc_ff, crc_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_ff, out_in;
   logic           emit;
   logic           is_last;
   logic [7:0]     cur_byte;
   logic [3:0]     pay_pos;

   assign emit    = active_ff && (!out_valid_ff || rsp_pop);
   assign is_last = desc_ff.protocol ? (idx_ff == LAST_PROTOCOL) : (idx_ff == LAST_PLAIN);
   assign q_pop   = !q_empty && (!active_ff || (emit && is_last));

   always_comb begin
      pay_pos  = idx_ff - (desc_ff.protocol ? POS_PAY0 : POS_PLAIN_PAY0);
      cur_byte = PKT_PAD;
      if (idx_ff == POS_PREAMBLE) begin
         cur_byte = FRAME_PREAMBLE;
      end else if (idx_ff == POS_LENGTH) begin
         cur_byte = desc_ff.protocol ? LEN_PROTOCOL : LEN_PLAIN;
      end else if (!desc_ff.protocol) begin
         cur_byte = desc_ff.payload[{pay_pos[1:0], 3'b000} +: 8];
      end else begin
         case (idx_ff) inside
            POS_MAGIC:            cur_byte = PKT_MAGIC;
            POS_TYPE:             cur_byte = PKT_TYPE;
            POS_SESSION:          cur_byte = desc_ff.session_id;
            POS_SEQ:              cur_byte = desc_ff.seq;
            POS_PAD0, POS_PAD1:   cur_byte = PKT_PAD;
            [POS_PAY0:POS_PAY3]:  cur_byte = desc_ff.payload[{pay_pos[1:0], 3'b000} +: 8];
            POS_CRC_LO:           cur_byte = crc_ff[7:0];
            POS_CRC_HI:           cur_byte = crc_ff[15:8];
            default:              cur_byte = PKT_PAD;
         endcase
      end
   end

   always_comb begin
      desc_in      = desc_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in         = 1'b1;
         out_in.tx_byte       = cur_byte;
         out_in.last_byte     = is_last;
         out_in.radio_channel = desc_ff.channel;
         idx_in               = idx_ff + 4'd1;
         if (desc_ff.protocol && (idx_ff inside {[POS_MAGIC:POS_PAY3]})) begin
            crc_in = crc_byte(crc_ff, cur_byte);
         end
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      if (q_pop) begin
         desc_in   = q_data;
         active_in = 1'b1;
         idx_in    = POS_PREAMBLE;
         crc_in    = CRC_INIT;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      idx_ff  <= idx_in;
      crc_ff  <= crc_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/core/rf_packet_framer_crc16_unit.sv =====
// ----------------------------------------------------------------------------
// rf_packet_framer_crc16_unit
// Transmit-tick packet framer with CRC-16-CCITT and channel hopping.
// ----------------------------------------------------------------------------
// Each accepted req beat is one transmit tick and yields one frame on the rsp
// side, one byte per beat: 14 bytes in protocol mode, 6 in plain mode. The byte
// sequencer emits one byte per cycle unless the rsp side stalls it; a tick
// passes the queue, the descriptor register and the result register before
// its first byte shows on rsp. Up to QUEUE_DEPTH further ticks are buffered
// between the front end and the sequencer; req_full rises when that queue is
// full. Configuration is latched per tick at acceptance.
// ----------------------------------------------------------------------------
module rf_packet_framer_crc16_unit #(
   parameter int unsigned QUEUE_DEPTH = rfpf_pkg::RFPF_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   input  logic              req_push,
   input  rfpf_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   output rfpf_pkg::rsp_type rsp_data,
   input  logic              rsp_pop
);
   import rfpf_pkg::*;

   logic           q_push, q_full, q_pop, q_empty;
   frame_desc_type q_wdata, q_rdata;
   logic           rsp_valid;

   rfpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   rfpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rdata)
   );

   rfpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   assign req_full  = q_full;
   assign rsp_empty = !rsp_valid;

endmodule

// ===== dv/rf_packet_framer_crc16_unit_test.sv =====
// ----------------------------------------------------------------------------
// rf_packet_framer_crc16_unit_test
// Self-checking bench for the transmit-tick packet framer.
// ----------------------------------------------------------------------------
// Sends transmit ticks through the req queue and predicts every frame byte.
// The prediction tracks the sequence counter, the latched payload and the
// register settings. Each popped rsp beat is compared field by field against
// the oldest predicted byte. Directed ticks cover the default payload, payload
// hold, session id and channel extremes, and plain mode. Random traffic then
// runs under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module rf_packet_framer_crc16_unit_test;
   import rfpf_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_PROTOCOL_MODE;
   logic [7:0]    csr_wdata = '0;
   logic          req_push  = 1'b0;
   req_type       req_data  = '0;
   logic          req_full;
   logic          rsp_empty;
   rsp_type       rsp_data;
   logic          rsp_pop   = 1'b0;

   logic          cfg_protocol;
   logic          cfg_hop;
   logic [7:0]    cfg_session;
   logic [5:0]    cfg_channel;
   logic [7:0]    seq_count;
   logic [7:0]    last_sent_seq;
   logic [31:0]   held_word;
   logic          have_payload;

   rsp_type       frame_bytes_due[$];
   int            send_idle_pct = 0;
   int            rsp_stall_pct = 0;
   int            mismatches    = 0;
   int            cycles        = 0;

   rf_packet_framer_crc16_unit uut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc,
                                                  input logic [7:0] data);
      logic feedback;
      for (int b = 7; b >= 0; b--) begin
         feedback = crc[15] ^ data[b];
         crc = {crc[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
      end
      return crc;
   endfunction

   function automatic void predict_frame(input req_type tick);
      logic [7:0]  body[$];
      logic [31:0] word;
      logic [15:0] crc;
      logic [5:0]  chan;
      rsp_type     beat;
      if (tick.payload_valid) begin
         held_word    = tick.payload_word;
         have_payload = 1'b1;
      end
      word = have_payload ? held_word : DEFAULT_PAYLOAD;
      body = {FRAME_PREAMBLE};
      if (cfg_protocol) begin
         body.push_back(LEN_PROTOCOL);
         body.push_back(PKT_MAGIC);
         body.push_back(PKT_TYPE);
         body.push_back(cfg_session);
         body.push_back(seq_count);
         body.push_back(PKT_PAD);
         body.push_back(PKT_PAD);
         for (int i = 0; i < 4; i++) body.push_back(word[8*i +: 8]);
         crc = CRC_INIT;
         for (int i = 2; i < 12; i++) crc = crc_ccitt_byte(crc, body[i]);
         body.push_back(crc[7:0]);
         body.push_back(crc[15:8]);
         last_sent_seq = seq_count;
         seq_count     = seq_count + 8'd1;
      end else begin
         body.push_back(LEN_PLAIN);
         for (int i = 0; i < 4; i++) body.push_back(word[8*i +: 8]);
      end
      chan = cfg_hop ? 6'(4 + 4 * ((int'(last_sent_seq) / 16) % HOP_COUNT)) : cfg_channel;
      foreach (body[i]) begin
         beat.tx_byte       = body[i];
         beat.last_byte     = (i == body.size() - 1);
         beat.radio_channel = chan;
         frame_bytes_due.push_back(beat);
      end
   endfunction

   task automatic send_tick(input logic valid, input logic [31:0] word);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push                = 1'b0;
         req_data.payload_valid  = 1'($urandom_range(1));
         req_data.payload_word   = $urandom;
         @(negedge clock);
      end
      req_data.payload_valid = valid;
      req_data.payload_word  = word;
      req_push               = 1'b1;
      do @(posedge clock); while (req_full);
      predict_frame(req_data);
   endtask

   task automatic settle();
      @(negedge clock);
      req_push = 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      settle();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_PROTOCOL_MODE: cfg_protocol = value[0];
         CSR_HOP_ENABLE:    cfg_hop      = value[0];
         CSR_SESSION_ID:    cfg_session  = value;
         CSR_FIXED_CHANNEL: cfg_channel  = value[5:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic protocol, input logic hop,
                            input logic [7:0] session, input logic [5:0] channel);
      write_reg(CSR_PROTOCOL_MODE, {7'd0, protocol});
      write_reg(CSR_HOP_ENABLE, {7'd0, hop});
      write_reg(CSR_SESSION_ID, session);
      write_reg(CSR_FIXED_CHANNEL, {2'd0, channel});
   endtask

   // no payload seen yet: frames carry 1,2,3,4
   task automatic test_default_payload();
      send_tick(1'b0, 32'hFFFF_FFFF);
      write_reg(CSR_PROTOCOL_MODE, 8'd1);
      send_tick(1'b0, 32'h0000_0000);
   endtask

   task automatic test_payload_hold();
      send_tick(1'b1, 32'h0000_0000);
      send_tick(1'b1, 32'hFFFF_FFFF);
      send_tick(1'b0, 32'h0000_0000);
      send_tick(1'b1, 32'hA5A5_A5A5);
      send_tick(1'b1, 32'h5A5A_5A5A);
      send_tick(1'b0, 32'hFFFF_FFFF);
   endtask

   task automatic test_session_id();
      write_reg(CSR_SESSION_ID, 8'd0);
      send_tick(1'b1, 32'h1234_5678);
      write_reg(CSR_SESSION_ID, 8'd255);
      send_tick(1'b0, $urandom);
   endtask

   task automatic test_channel_select();
      configure(1'b1, 1'b0, 8'd33, 6'd0);
      send_tick(1'b1, $urandom);
      write_reg(CSR_FIXED_CHANNEL, 8'd39);
      send_tick(1'b0, $urandom);
      // out of range channel goes out as is
      write_reg(CSR_FIXED_CHANNEL, 8'd63);
      send_tick(1'b1, $urandom);
      write_reg(CSR_HOP_ENABLE, 8'd1);
      repeat (3) send_tick(1'($urandom_range(1)), $urandom);
   endtask

   // plain frames leave the sequence alone; hop channel follows the last seq
   task automatic test_plain_mode();
      configure(1'b0, 1'b1, 8'd33, 6'd16);
      send_tick(1'b1, $urandom);
      send_tick(1'b0, $urandom);
      write_reg(CSR_HOP_ENABLE, 8'd0);
      send_tick(1'b1, $urandom);
   endtask

   task automatic run_random_phase(input int send_pct, input int stall_pct,
                                   input bit with_plain);
      for (int g = 0; g < 3; g++) begin
         configure(!(with_plain && g == 1), 1'($urandom_range(1)),
                   8'($urandom_range(255)), 6'($urandom_range(63)));
         send_idle_pct = send_pct;
         rsp_stall_pct = stall_pct;
         repeat (16) send_tick(1'($urandom_range(1)), $urandom);
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, 1'b0);
      run_random_phase(56, 0, 1'b0);
      run_random_phase(0, 56, 1'b1);
      run_random_phase(33, 33, 1'b0);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (frame_bytes_due.size() == 0) begin
            $error("unexpected beat: tx_byte %0h", rsp_data.tx_byte);
            mismatches++;
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_data.tx_byte !== want.tx_byte) begin
               $error("tx_byte expected %0h actual %0h", want.tx_byte, rsp_data.tx_byte);
               mismatches++;
            end
            if (rsp_data.last_byte !== want.last_byte) begin
               $error("last_byte expected %0b actual %0b", want.last_byte,
                      rsp_data.last_byte);
               mismatches++;
            end
            if (rsp_data.radio_channel !== want.radio_channel) begin
               $error("radio_channel expected %0d actual %0d", want.radio_channel,
                      rsp_data.radio_channel);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("rf_packet_framer_crc16_unit: mismatch");
         $finish;
      end
   end

   initial begin
      cfg_protocol  = 1'b0;
      cfg_hop       = 1'b0;
      cfg_session   = RST_SESSION_ID;
      cfg_channel   = RST_FIXED_CHANNEL;
      seq_count     = '0;
      last_sent_seq = '0;
      held_word     = '0;
      have_payload  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_payload();
      test_payload_hold();
      test_session_id();
      test_channel_select();
      test_plain_mode();
      test_random_traffic();
      settle();

      if (mismatches == 0) begin
         $display("rf_packet_framer_crc16_unit: match");
      end else begin
         $display("rf_packet_framer_crc16_unit: mismatch");
      end
      $finish;
   end

endmodule
